// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/pipt_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Default sizes, opcodes and the sequencer state type.
// ----------------------------------------------------------------------------
package pipt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;
    localparam int INDEX_BITS       = 6;
    localparam int COUNT_BITS       = 7;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADJ,
        S_MUL1,
        S_MUL2,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// File: sv/pipt_if.sv
// ----------------------------------------------------------------------------
// Point-in-polygon channels
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface pipt_in_if #(
    parameter int COORD_BITS = pipt_pkg::COORD_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic [pipt_pkg::INDEX_BITS-1:0]      vertex_index;
    logic signed [COORD_BITS-1:0]         x_coord;
    logic signed [COORD_BITS-1:0]         y_coord;

    modport source (output valid, opcode, vertex_index, x_coord, y_coord, input ready);
    modport sink   (input valid, opcode, vertex_index, x_coord, y_coord, output ready);
endinterface

interface pipt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 inside_res;
    logic [pipt_pkg::COUNT_BITS-1:0]      left_crossings;

    modport source (output valid, inside_res, left_crossings, input ready);
    modport sink   (input valid, inside_res, left_crossings, output ready);
endinterface

// File: sv/point_in_polygon_test_top.sv
// Loads are taken every cycle while idle. A query reads the closing vertex, then
// takes each edge through S_MUL1 and S_MUL2 on the single shared multiplier, which
// forms two cross products per edge, then S_FIN and S_DONE, which loads the result
// register once it holds no untaken result. With the vertex count in use (capped at
// MAX_VERTICES) at zero, a query goes straight to S_DONE. New items wait for S_IDLE.
// Reset: synchronous, active low; clears sequencer, result valid flag and vertex count.
// ----------------------------------------------------------------------------
// Point-in-polygon test top level
// Even-odd ray casting over a vertex store, one edge per two multiplier passes.
// The vertex store is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pipt_pkg::COUNT_BITS-1:0] i_cfg_wdata,
    pipt_in_if.sink                         i_pnt,
    pipt_out_if.source                      o_res
);
    import pipt_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int VW = 2 * COORD_BITS;

    logic [VW-1:0] mem [MAX_VERTICES];

    t_state                   r_state, n_state;
    logic [COUNT_BITS-1:0]    r_vertex_count;
    logic [VW-1:0]            r_rd_data;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_last;
    logic [CW-1:0]            r_cnt;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_xi, r_yi, r_xj, r_yj;
    logic signed [PW-1:0]     r_p, r_q;
    logic                     r_strad, r_dypos, r_pend;
    logic                     r_out_valid, r_out_inside;
    logic [COUNT_BITS-1:0]    r_out_left;

    logic                     w_accept, w_load_wr, w_rd_en, w_hit;
    logic [AW-1:0]            w_rd_addr, w_wr_addr;
    logic [31:0]              w_slot32, w_cnt32, w_neff32;
    logic signed [COORD_BITS-1:0] w_rx, w_ry;
    logic signed [DW-1:0]     w_mul_a, w_mul_b;
    logic signed [PW-1:0]     w_prod;
    logic [COUNT_BITS-1:0]    w_sat;

    assign i_pnt.ready      = (r_state == S_IDLE);
    assign w_accept         = i_pnt.valid && i_pnt.ready;
    assign w_slot32         = 32'(i_pnt.vertex_index);
    assign w_wr_addr        = w_slot32[AW-1:0];
    assign w_load_wr        = w_accept && (i_pnt.opcode == OP_LOAD)
                              && (w_slot32 < 32'(MAX_VERTICES));
    assign w_cnt32          = 32'(r_vertex_count);
    assign w_neff32         = (w_cnt32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : w_cnt32;
    assign w_rx             = r_rd_data[VW-1:COORD_BITS];
    assign w_ry             = r_rd_data[COORD_BITS-1:0];
    assign w_prod           = w_mul_a * w_mul_b;
    assign w_hit            = r_pend && r_strad && (r_dypos ? (r_p <= r_q) : (r_p >= r_q));
    assign w_sat            = (32'(r_cnt) > 32'd127) ? 7'd127 : COUNT_BITS'(r_cnt);

    assign o_res.valid          = r_out_valid;
    assign o_res.inside_res     = r_out_inside;
    assign o_res.left_crossings = r_out_left;

    // vertex store
    always_ff @(posedge i_clk) begin
        if (w_load_wr) begin
            mem[w_wr_addr] <= {i_pnt.x_coord, i_pnt.y_coord};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        w_mul_a   = DW'(r_px) - DW'(r_xi);
        w_mul_b   = DW'(r_yi) - DW'(r_yj);
        unique case (r_state)
            S_IDLE: begin
                w_rd_addr = AW'(w_neff32 - 32'd1);
                if (w_accept && (i_pnt.opcode == OP_QUERY)) begin
                    w_rd_en = 1'b1;
                    n_state = (w_neff32 == 32'd0) ? S_DONE : S_LOADJ;
                end
            end
            S_LOADJ: begin
                w_rd_en = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                w_mul_a = DW'(r_py) - DW'(w_ry);
                w_mul_b = DW'(w_rx) - DW'(r_xj);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                w_rd_addr = r_idx + AW'(1);
                w_rd_en   = (r_idx != r_last);
                n_state   = (r_idx != r_last) ? S_MUL1 : S_FIN;
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_out_valid    <= 1'b0;
            r_pend         <= 1'b0;
            r_cnt          <= '0;
            r_idx          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
            r_pend <= (r_state == S_MUL2);
            if (w_hit) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_px   <= i_pnt.x_coord;
                        r_py   <= i_pnt.y_coord;
                        r_cnt  <= '0;
                        r_idx  <= '0;
                        r_last <= AW'(w_neff32 - 32'd1);
                    end
                end
                S_LOADJ: begin
                    r_xj <= w_rx;
                    r_yj <= w_ry;
                end
                S_MUL1: begin
                    r_xi    <= w_rx;
                    r_yi    <= w_ry;
                    r_p     <= w_prod;
                    r_strad <= ((w_ry < r_py) && (r_yj >= r_py))
                               || ((r_yj < r_py) && (w_ry >= r_py));
                    r_dypos <= (w_ry > r_yj);
                end
                S_MUL2: begin
                    r_q  <= w_prod;
                    r_xj <= r_xi;
                    r_yj <= r_yi;
                    r_idx <= r_idx + AW'(1);
                end
                S_FIN: begin
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= r_cnt[0];
                        r_out_left   <= w_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `ASSERT_IMP(a_idx_in_range, (r_state == S_MUL1) || (r_state == S_MUL2), r_idx <= r_last)
    `ASSERT_IMP(a_cnt_bounded, r_state != S_IDLE, 32'(r_cnt) <= 32'(MAX_VERTICES))
    `ASSERT_NEXT(a_mul_pair, r_state == S_MUL1, r_state == S_MUL2)
    `ASSERT_IMP(a_no_pend_at_done, r_state == S_DONE, !r_pend)

endmodule

// File: dv/point_in_polygon_test_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Watches the count register and both channels, keeps its own vertex store,
// predicts each query by even-odd ray casting and compares results in order.
// ----------------------------------------------------------------------------
module point_in_polygon_test_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pipt_pkg::COUNT_BITS-1:0] i_cfg_wdata,
    pipt_in_if                              i_pnt,
    pipt_out_if                             i_res,
    output int                              o_fail_count,
    output int                              o_pending
);
    import pipt_pkg::*;

    typedef logic signed [COORD_BITS_DEF-1:0] t_coord;

    typedef struct packed {
        logic                  inside_res;
        logic [COUNT_BITS-1:0] left_crossings;
    } t_polygon_verdict;

    t_coord                shadow_x [MAX_VERTICES_DEF];
    t_coord                shadow_y [MAX_VERTICES_DEF];
    logic [COUNT_BITS-1:0] shadow_count = '0;
    t_polygon_verdict      verdict_q [$];
    int                    fail_tally = 0;
    int                    pending_tally = 0;

    assign o_fail_count = fail_tally;
    assign o_pending    = pending_tally;

    function automatic t_polygon_verdict ray_cast(input t_coord px, input t_coord py);
        t_polygon_verdict verdict;
        int               n;
        int               prev;
        int unsigned      hits;
        longint           qx, qy, xa, ya, xb, yb, dy, lhs, rhs;
        n = (shadow_count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(shadow_count);
        qx = px;
        qy = py;
        hits = 0;
        prev = n - 1;
        for (int k = 0; k < n; k++) begin
            xa = shadow_x[k];
            ya = shadow_y[k];
            xb = shadow_x[prev];
            yb = shadow_y[prev];
            if ((ya < qy) != (yb < qy)) begin
                // crossing x at or left of the point, with the division cross-multiplied
                dy  = ya - yb;
                lhs = (qy - ya) * (xa - xb);
                rhs = (qx - xa) * dy;
                if ((dy > 0) ? (lhs <= rhs) : (lhs >= rhs)) begin
                    hits++;
                end
            end
            prev = k;
        end
        verdict.inside_res     = hits[0];
        verdict.left_crossings = (hits > 127) ? {COUNT_BITS{1'b1}} : hits[COUNT_BITS-1:0];
        return verdict;
    endfunction

    always @(posedge i_clk) begin
        t_polygon_verdict want;
        if (!i_rst_n) begin
            shadow_count = '0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                shadow_count = i_cfg_wdata;
            end
            if (i_pnt.valid && i_pnt.ready) begin
                if (i_pnt.opcode == OP_LOAD) begin
                    shadow_x[i_pnt.vertex_index] = i_pnt.x_coord;
                    shadow_y[i_pnt.vertex_index] = i_pnt.y_coord;
                end else begin
                    verdict_q.push_back(ray_cast(i_pnt.x_coord, i_pnt.y_coord));
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (verdict_q.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected result transfer: inside_res %b left_crossings %0d",
                             $time, i_res.inside_res, i_res.left_crossings);
                end else begin
                    want = verdict_q.pop_front();
                    if (i_res.inside_res !== want.inside_res) begin
                        fail_tally++;
                        $display("%0t: inside_res expected %b got %b",
                                 $time, want.inside_res, i_res.inside_res);
                    end
                    if (i_res.left_crossings !== want.left_crossings) begin
                        fail_tally++;
                        $display("%0t: left_crossings expected %0d got %0d",
                                 $time, want.left_crossings, i_res.left_crossings);
                    end
                end
            end
        end
        pending_tally = verdict_q.size();
    end

endmodule

// File: dv/point_in_polygon_test_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-in-polygon testbench
// Loads vertex sets, steps the vertex count through its range and fires
// directed then random query points under bursty input and stalled output.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top_tb;
    import pipt_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LOAD_SETTLE   = 8;
    localparam int QUERY_SETTLE  = 2 * MAX_VERTICES_DEF + 3 + 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 16;
    localparam int PHASE_ITEMS   = 60;
    localparam int FULL_SPAN     = 32767;

    typedef logic signed [COORD_BITS_DEF-1:0] t_coord;
    typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_mode;

    localparam t_coord C_MAX = 16'sh7FFF;
    localparam t_coord C_MIN = 16'sh8000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [COUNT_BITS-1:0] i_cfg_wdata = '0;

    int     fail_count;
    int     pending;
    int     cycle_count = 0;
    int     burst_left  = 0;
    logic   hold_req    = 1'b0;
    logic   loaded [MAX_VERTICES_DEF];
    t_coord stim_x [MAX_VERTICES_DEF];
    t_coord stim_y [MAX_VERTICES_DEF];

    pipt_in_if  pnt_if ();
    pipt_out_if res_if ();

    point_in_polygon_test_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pnt       (pnt_if),
        .o_res       (res_if)
    );

    point_in_polygon_test_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pnt        (pnt_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("point_in_polygon_test_top_tb failed");
        $finish;
    end

    initial begin
        t_rx_mode rx_mode;
        int       mode_left;
        res_if.ready = 1'b0;
        rx_mode      = RX_OPEN;
        mode_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = t_rx_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   res_if.ready = 1'b1;
                    RX_RANDOM: res_if.ready = 1'($urandom_range(0, 1));
                    default:   res_if.ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic t_coord rand_coord(input int span);
        logic [31:0] r;
        r = $urandom;
        if (span >= FULL_SPAN) begin
            return r[COORD_BITS_DEF-1:0];
        end
        return t_coord'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic send_item(input logic op, input logic [INDEX_BITS-1:0] idx,
                             input t_coord x, input t_coord y);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                pnt_if.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        pnt_if.valid        = 1'b1;
        pnt_if.opcode       = op;
        pnt_if.vertex_index = idx;
        pnt_if.x_coord      = x;
        pnt_if.y_coord      = y;
        do @(posedge i_clk); while (pnt_if.ready !== 1'b1);
        if (op == OP_LOAD) begin
            loaded[idx] = 1'b1;
            stim_x[idx] = x;
            stim_y[idx] = y;
        end
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        pnt_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_vertex_count(input int value);
        drain(LOAD_SETTLE);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value[COUNT_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // load every slot that the coming count will read and that is still unwritten
    task automatic fill_slots(input int value, input int span);
        int n;
        n = (value > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : value;
        for (int k = 0; k < n; k++) begin
            if (!loaded[k]) begin
                send_item(OP_LOAD, k[INDEX_BITS-1:0], rand_coord(span), rand_coord(span));
            end
        end
    endtask

    initial begin
        int     value;
        int     span;
        int     n_used;
        int     k;
        int     pick;
        t_coord qx;
        t_coord qy;
        pnt_if.valid        = 1'b0;
        pnt_if.opcode       = OP_LOAD;
        pnt_if.vertex_index = '0;
        pnt_if.x_coord      = '0;
        pnt_if.y_coord      = '0;
        for (int s = 0; s < MAX_VERTICES_DEF; s++) begin
            loaded[s] = 1'b0;
            stim_x[s] = '0;
            stim_y[s] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty polygon straight after reset
        send_item(OP_QUERY, 6'h3F, C_MAX, C_MIN);

        send_item(OP_LOAD, 6'd0, C_MIN, C_MIN);
        send_item(OP_LOAD, 6'd1, C_MAX, C_MIN);
        send_item(OP_LOAD, 6'd2, 16'sd0, C_MAX);
        send_item(OP_LOAD, 6'h3F, -16'sd1, 16'shAAAA);

        set_vertex_count(3);
        send_item(OP_QUERY, 6'd0, 16'sd0, 16'sd0);
        send_item(OP_QUERY, 6'd0, C_MIN, 16'sd0);
        send_item(OP_QUERY, 6'd0, C_MAX, C_MAX);
        send_item(OP_QUERY, 6'd0, 16'sd0, C_MIN);
        send_item(OP_QUERY, 6'd0, 16'sd0, C_MAX);
        send_item(OP_QUERY, 6'h2A, 16'sh5555, 16'shAAAA);
        send_item(OP_QUERY, 6'h15, -16'sd1, -16'sd1);

        // degenerate counts stay outside
        set_vertex_count(1);
        send_item(OP_QUERY, 6'd0, 16'sd0, 16'sd0);
        set_vertex_count(2);
        send_item(OP_QUERY, 6'd0, 16'sd0, C_MIN);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1:       value = MAX_VERTICES_DEF;
                4:       value = 127;
                7:       value = MAX_VERTICES_DEF + 1;
                9:       value = 0;
                12:      value = 2;
                default: value = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 2))
                0:       span = FULL_SPAN;
                1:       span = 1000;
                default: span = 12;
            endcase
            n_used = (value > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : value;
            fill_slots(value, span);
            set_vertex_count(value);
            if (phase == 3 || phase == 10) begin
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(OP_LOAD, INDEX_BITS'($urandom_range(0, MAX_VERTICES_DEF - 1)),
                              rand_coord(span), rand_coord(span));
                end else begin
                    pick = $urandom_range(0, 3);
                    qx = rand_coord(span);
                    qy = rand_coord(span);
                    if (n_used > 0 && pick < 2) begin
                        k  = $urandom_range(0, n_used - 1);
                        qy = stim_y[k];
                        if (pick == 0) begin
                            qx = stim_x[k];
                        end
                    end
                    send_item(OP_QUERY, INDEX_BITS'($urandom_range(0, MAX_VERTICES_DEF - 1)),
                              qx, qy);
                end
            end
        end

        drain(QUERY_SETTLE);
        if (fail_count == 0) begin
            $display("point_in_polygon_test_top_tb passed");
        end else begin
            $display("point_in_polygon_test_top_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/pipt_pkg.sv
sv/pipt_if.sv
sv/point_in_polygon_test_top.sv
dv/point_in_polygon_test_checker.sv
dv/point_in_polygon_test_top_tb.sv
